// ----- src/mps_pkg.sv -----
// Shared types, tables and codes for the MIDI pitch speller pipeline.
package mps_pkg;

    // Configuration register indexes
    localparam logic CFG_KEY_SIG      = 1'b0;
    localparam logic CFG_PREFER_FLATS = 1'b1;

    // Forced accidental codes on the input
    localparam logic [1:0] FORCE_NONE    = 2'd0;
    localparam logic [1:0] FORCE_FLAT    = 2'd1;
    localparam logic [1:0] FORCE_SHARP   = 2'd2;
    localparam logic [1:0] FORCE_NATURAL = 2'd3;

    // Accidental codes on the output
    localparam logic [1:0] ACC_NONE    = 2'd0;
    localparam logic [1:0] ACC_NATURAL = 2'd1;
    localparam logic [1:0] ACC_SHARP   = 2'd2;
    localparam logic [1:0] ACC_FLAT    = 2'd3;

    // Letter numbers used for the octave corrections
    localparam logic [2:0] DEG_C = 3'd0;
    localparam logic [2:0] DEG_B = 3'd6;

    // Bottom line of each staff, in diatonic steps from C0
    localparam int TREBLE_REF = 4 * 7 + 2;
    localparam int BASS_REF   = 2 * 7 + 4;

    // Lowest note on the treble staff
    localparam logic [6:0] TREBLE_LOW = 7'd60;

    // Reciprocal of 12 for a 7-bit note: q = (n * 171) >> 11
    localparam logic [7:0] RECIP12  = 8'd171;
    localparam int         RECIP_SH = 11;

    typedef logic [3:0] t_nib_arr7  [7];
    typedef logic [2:0] t_deg_arr7  [7];
    typedef logic [2:0] t_deg_arr12 [12];

    localparam t_nib_arr7 LETTER_CHROMA = '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11};
    localparam t_deg_arr7 SHARP_SEQ     = '{3'd3, 3'd0, 3'd4, 3'd1, 3'd5, 3'd2, 3'd6};
    localparam t_deg_arr7 FLAT_SEQ      = '{3'd6, 3'd2, 3'd5, 3'd1, 3'd4, 3'd0, 3'd3};
    localparam t_deg_arr12 LETTER_UP    = '{3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd3,
                                            3'd3, 3'd4, 3'd4, 3'd5, 3'd5, 3'd6};
    localparam t_deg_arr12 LETTER_DOWN  = '{3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3,
                                            3'd4, 3'd4, 3'd5, 3'd5, 3'd6, 3'd6};
    // Bit p set when pitch class p is a black key (1, 3, 6, 8, 10)
    localparam logic [11:0] BLACK_KEY = 12'b0101_0100_1010;

    // Stage 1 to stage 2 payload
    typedef struct packed {
        logic       staff;
        logic [3:0] quot;
        logic [3:0] pc;
        logic [1:0] force_acc;
        logic [6:0] sharp_mask;
        logic [6:0] flat_mask;
        logic       flats;
    } t_s1;

    // Stage 2 to stage 3 payload
    typedef struct packed {
        logic       staff;
        logic [3:0] quot;
        logic [3:0] pc;
        logic [2:0] degree;
        logic [1:0] accidental;
    } t_s2;

    // Pitch class one step up, modulo 12
    function automatic logic [3:0] pc_up(input logic [3:0] pc);
        pc_up = (pc == 4'd11) ? 4'd0 : pc + 4'd1;
    endfunction

    // Pitch class one step down, modulo 12
    function automatic logic [3:0] pc_down(input logic [3:0] pc);
        pc_down = (pc == 4'd0) ? 4'd11 : pc - 4'd1;
    endfunction

endpackage

// ----- src/midi_pitch_speller.sv -----
// Top level of the MIDI pitch speller: configuration registers and pipeline control.
// Names one MIDI note per item as a letter (0 C .. 6 B) with an accidental under the
// programmed key signature, picks treble or bass staff, and gives the staff position
// and stem direction. The block takes one item every clock cycle unless the input
// is stalled; the three register stages (note split and key decode, spelling, staff
// placement) hold each item in turn, and the last stage is the output register. A
// stall on the output fills empty stages first, so the input is stalled only once all
// three stages hold items. Configuration writes are always ready and take effect for
// items accepted afterward; write them only while the pipeline is empty. A key
// signature of -8 is stored as -7.
module midi_pitch_speller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input item channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [6:0]        i_note_number,
    input  logic [1:0]        i_forced_accidental,
    // Result item channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_staff,
    output logic [2:0]        o_degree,
    output logic [1:0]        o_accidental,
    output logic signed [6:0] o_staff_position,
    output logic              o_stem_down,
    // Configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [3:0]        i_cfg_data
);
    import mps_pkg::*;

    logic signed [3:0] r_key_sig;
    logic              r_prefer_flats;
    logic              adv1;
    logic              adv2;
    logic              adv3;
    logic              s1_valid;
    logic              s2_valid;
    t_s1               s1;
    t_s2               s2;

    assign o_cfg_ready = 1'b1;

    // Store configuration, clamping the key signature to -7..+7
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_sig      <= 4'sd0;
            r_prefer_flats <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_KEY_SIG: begin
                    r_key_sig <= (i_cfg_data == 4'b1000) ? -4'sd7 : $signed(i_cfg_data);
                end
                CFG_PREFER_FLATS: begin
                    r_prefer_flats <= i_cfg_data[0];
                end
                default: ;
            endcase
        end
    end

    // Advance a stage when it is empty or the stage after it advances
    assign adv3    = !o_valid || !i_stall;
    assign adv2    = !s2_valid || adv3;
    assign adv1    = !s1_valid || adv2;
    assign o_stall = !adv1;

    mps_split u_split (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_adv               (adv1),
        .i_valid             (i_valid),
        .i_note_number       (i_note_number),
        .i_forced_accidental (i_forced_accidental),
        .i_key_sig           (r_key_sig),
        .i_prefer_flats      (r_prefer_flats),
        .o_valid             (s1_valid),
        .o_s1                (s1)
    );

    mps_spell u_spell (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv2),
        .i_valid (s1_valid),
        .i_s1    (s1),
        .o_valid (s2_valid),
        .o_s2    (s2)
    );

    mps_place u_place (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (adv3),
        .i_valid          (s2_valid),
        .i_s2             (s2),
        .o_valid          (o_valid),
        .o_staff          (o_staff),
        .o_degree         (o_degree),
        .o_accidental     (o_accidental),
        .o_staff_position (o_staff_position),
        .o_stem_down      (o_stem_down)
    );

    // Input stalls only when every stage is full and the output is stalled
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall && s1_valid && s2_valid))
        else $error("input stalled with room in the pipeline");

    // Treble results sit no lower than B-sharp below middle C allows
    a_treble_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_staff) |-> (o_staff_position >= -7'sd3))
        else $error("treble staff position out of range");

    // Bass results sit no higher than C-flat above B3 allows
    a_bass_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_staff) |-> (o_staff_position <= 7'sd10))
        else $error("bass staff position out of range");

    // A stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_degree)
                                  && $stable(o_staff_position)))
        else $error("stalled result changed");

endmodule

// ----- src/mps_split.sv -----
// Stage 1: split the note into octave and pitch class, decode the key signature.
module mps_split (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  logic [6:0]        i_note_number,
    input  logic [1:0]        i_forced_accidental,
    input  logic signed [3:0] i_key_sig,
    input  logic              i_prefer_flats,
    output logic              o_valid,
    output mps_pkg::t_s1      o_s1
);
    import mps_pkg::*;

    logic        r_valid;
    t_s1         r_s1;
    t_s1         n_s1;
    logic [14:0] prod;
    logic [2:0]  key_cnt;

    always_comb begin
        // Divide by 12 through the reciprocal, then take the remainder
        prod           = {8'd0, i_note_number} * {7'd0, RECIP12};
        n_s1.quot      = prod[RECIP_SH +: 4];
        n_s1.pc        = 4'(i_note_number - ({3'd0, n_s1.quot} * 7'd12));
        n_s1.staff     = (i_note_number < TREBLE_LOW);
        n_s1.force_acc = i_forced_accidental;

        // Mark the letters the key alters
        key_cnt = i_key_sig[3] ? 3'(-i_key_sig) : i_key_sig[2:0];
        n_s1.sharp_mask = '0;
        n_s1.flat_mask  = '0;
        for (int i = 0; i < 7; i++) begin
            if (3'(i) < key_cnt) begin
                if (i_key_sig[3]) n_s1.flat_mask[FLAT_SEQ[i]] = 1'b1;
                else              n_s1.sharp_mask[SHARP_SEQ[i]] = 1'b1;
            end
        end
        n_s1.flats = i_key_sig[3] || ((i_key_sig == 4'sd0) && i_prefer_flats);
    end

    // Hold while this stage is full and the next stage is full and stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1 <= n_s1;
        end
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule

// ----- src/mps_spell.sv -----
// Stage 2: choose the letter and accidental for the note.
module mps_spell (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_adv,
    input  logic         i_valid,
    input  mps_pkg::t_s1 i_s1,
    output logic         o_valid,
    output mps_pkg::t_s2 o_s2
);
    import mps_pkg::*;

    logic       r_valid;
    t_s2        r_s2;
    t_s2        n_s2;
    logic [3:0] chroma [7];
    logic [6:0] hit;
    logic       found;
    logic [2:0] key_deg;
    logic [2:0] out_deg;
    logic [3:0] nat;
    logic       altered;

    // Altered pitch class of every letter, compared against the note
    always_comb begin
        for (int d = 0; d < 7; d++) begin
            chroma[d] = LETTER_CHROMA[d];
            if (i_s1.sharp_mask[d])     chroma[d] = pc_up(LETTER_CHROMA[d]);
            else if (i_s1.flat_mask[d]) chroma[d] = pc_down(LETTER_CHROMA[d]);
            hit[d] = (chroma[d] == i_s1.pc);
        end
    end

    // Lowest matching letter wins
    always_comb begin
        found   = |hit;
        key_deg = 3'd0;
        for (int d = 6; d >= 0; d--) begin
            if (hit[d]) key_deg = 3'(d);
        end
    end

    // Spell in key where a letter matches, else out of key, then apply any forced accidental
    always_comb begin
        if (BLACK_KEY[i_s1.pc] && i_s1.flats) out_deg = LETTER_DOWN[i_s1.pc];
        else                                   out_deg = LETTER_UP[i_s1.pc];
        nat     = LETTER_CHROMA[out_deg];
        altered = i_s1.sharp_mask[out_deg] | i_s1.flat_mask[out_deg];

        if (found) begin
            n_s2.degree     = key_deg;
            n_s2.accidental = ACC_NONE;
        end else begin
            n_s2.degree = out_deg;
            if (i_s1.pc == nat && altered)      n_s2.accidental = ACC_NATURAL;
            else if (i_s1.pc == pc_up(nat))     n_s2.accidental = ACC_SHARP;
            else if (i_s1.pc == pc_down(nat))   n_s2.accidental = ACC_FLAT;
            else if (i_s1.flats)                n_s2.accidental = ACC_FLAT;
            else                                n_s2.accidental = ACC_SHARP;
        end

        case (i_s1.force_acc)
            FORCE_FLAT: begin
                n_s2.degree     = LETTER_UP[pc_up(i_s1.pc)];
                n_s2.accidental = ACC_FLAT;
            end
            FORCE_SHARP: begin
                n_s2.degree     = LETTER_UP[pc_down(i_s1.pc)];
                n_s2.accidental = ACC_SHARP;
            end
            FORCE_NATURAL: begin
                n_s2.degree     = LETTER_UP[i_s1.pc];
                n_s2.accidental = ACC_NATURAL;
            end
            default: ;
        endcase

        n_s2.staff = i_s1.staff;
        n_s2.quot  = i_s1.quot;
        n_s2.pc    = i_s1.pc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_valid;
    assign o_s2    = r_s2;

endmodule

// ----- src/mps_place.sv -----
// Stage 3: staff position and stem direction, held in the output register.
module mps_place (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  mps_pkg::t_s2      i_s2,
    output logic              o_valid,
    output logic              o_staff,
    output logic [2:0]        o_degree,
    output logic [1:0]        o_accidental,
    output logic signed [6:0] o_staff_position,
    output logic              o_stem_down
);
    import mps_pkg::*;

    logic              r_valid;
    logic              r_staff;
    logic [2:0]        r_degree;
    logic [1:0]        r_accidental;
    logic signed [6:0] r_pos;
    logic              r_stem_down;
    logic signed [7:0] oct;
    logic signed [7:0] pos;

    // Octave with the B-sharp and C-flat corrections, then steps above the bottom line
    always_comb begin
        oct = $signed({4'd0, i_s2.quot}) - 8'sd1;
        if (i_s2.degree == DEG_B && i_s2.pc < 4'd2)  oct = oct - 8'sd1;
        if (i_s2.degree == DEG_C && i_s2.pc > 4'd10) oct = oct + 8'sd1;
        pos = (oct <<< 3) - oct + $signed({5'd0, i_s2.degree})
              - (i_s2.staff ? 8'(BASS_REF) : 8'(TREBLE_REF));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_staff      <= i_s2.staff;
            r_degree     <= i_s2.degree;
            r_accidental <= i_s2.accidental;
            r_pos        <= pos[6:0];
            r_stem_down  <= (pos >= 8'sd4);
        end
    end

    assign o_valid          = r_valid;
    assign o_staff          = r_staff;
    assign o_degree         = r_degree;
    assign o_accidental     = r_accidental;
    assign o_staff_position = r_pos;
    assign o_stem_down      = r_stem_down;

endmodule
